>>> sv/dgc_pkg.sv
`default_nettype none
package dgc_pkg;
  localparam int CHANNELS = 4;
  localparam int CH_W = 2;

  typedef enum logic [2:0] {
    CMD_TICK = 3'd0, CMD_INIT = 3'd1, CMD_SET = 3'd2, CMD_TOGGLE = 3'd3,
    CMD_PULSE = 3'd4, CMD_GET = 3'd5, CMD_SAFE = 3'd6, CMD_BAD = 3'd7
  } cmd_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_ARG   = 2'd1;
  localparam logic [1:0] ST_STATE = 2'd2;

  localparam logic [1:0] KIND_REPLY  = 2'd0;
  localparam logic [1:0] KIND_CHANGE = 2'd1;
  localparam logic [1:0] KIND_PULSE  = 2'd2;

  localparam logic [1:0] MODE_OFF = 2'd0;
  localparam logic [1:0] MODE_IN  = 2'd1;
  localparam logic [1:0] MODE_OUT = 2'd2;
  localparam logic [1:0] MODE_BAD = 2'd3;

  localparam logic [1:0] REG_MODES = 2'd0;
  localparam logic [1:0] REG_ALOW  = 2'd1;
  localparam logic [1:0] REG_DEB   = 2'd2;
  localparam logic [1:0] REG_POLL  = 2'd3;

  typedef struct packed {
    logic [2:0]  command;
    logic [2:0]  channel;
    logic        value;
    logic [23:0] pulse_len;
    logic [3:0]  pin_levels;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [2:0]  chan_id;
    logic        is_active;
    logic        pin_high;
    logic        was_active;
    logic        pulse_running;
    logic [31:0] change_stamp;
    logic [3:0]  pin_drive;
    logic        last;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic          load;     // capture input beat, advance time on tick
    logic          pulse_ch; // pulse countdown step for chan idx
    logic          poll_ch;  // poll step for chan idx
    logic          init_ch;  // init step for chan idx
    logic          exec;     // single-step command
    logic [CH_W-1:0] idx;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic       hit;       // current channel step emits a result
    logic       init_stop; // mode 3 found during init
    logic       poll_now;  // this tick polls
    logic       sel_en;    // addressed channel is valid and enabled
    logic       sel_out;   // addressed channel is an enabled output
    in_item_t   item;
  } dp_stat_t;
endpackage
`default_nettype wire

>>> sv/dgc_stream_if.sv
`default_nettype none
interface dgc_in_if;
  logic              valid;
  logic              ready;
  dgc_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface dgc_out_if;
  logic               valid;
  logic               ready;
  dgc_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> sv/debounced_gpio_channel_controller_core.sv
`default_nettype none
// Debounced four-channel GPIO controller core.
// Input beats (in_ channel, valid/ready) carry one command: tick, init, set,
// toggle, pulse, get or safe-off. Each beat yields zero to four result beats
// on the out_ channel (valid/ready); the final one has last set. A tick gives
// pulse-ended results first, then input change events, and none if nothing
// happened. Every other command gives exactly one reply.
// Sequence: the beat is taken in S_IDLE and decoded in S_LOAD; then a tick
// walks the four channels once for pulse countdown and, on poll ticks, once
// more for debounce; init walks the channels until done or a bad mode; other
// commands execute in S_EXEC; S_FLUSH sends the last beat. Only one command
// is in flight. When the receiver stalls, the walk waits with one result held
// and one in the output register; the input side is not ready until the item
// is done. Reset (rst_n, synchronous) clears all channel state, time and
// pending results, and loads the register defaults (debounce 30 ms, poll 5
// ticks). Configuration is written over the APB-style cfg_ port; the user
// must write it only while idle, as the block itself does not enforce this.
module debounced_gpio_channel_controller_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  dgc_in_if.sink           in_ch,
  dgc_out_if.source        out_ch,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  logic [7:0]  modes_r;
  logic        alow_r;
  logic [15:0] deb_r;
  logic [7:0]  poll_r;
  logic        wr;
  logic [1:0]  ridx;

  dgc_pkg::dp_cmd_t   cmd;
  dgc_pkg::dp_stat_t  stat;
  dgc_pkg::out_item_t view;

  assign cfg_pready = 1'b1;
  assign ridx = cfg_paddr[3:2];
  assign wr = cfg_psel && cfg_penable && cfg_pwrite;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modes_r <= '0; alow_r <= 1'b0; deb_r <= 16'd30; poll_r <= 8'd5;
    end else if (wr) begin
      case (ridx)
        dgc_pkg::REG_MODES: modes_r <= cfg_pwdata[7:0];
        dgc_pkg::REG_ALOW:  alow_r  <= cfg_pwdata[0];
        dgc_pkg::REG_DEB:   deb_r   <= cfg_pwdata[15:0];
        dgc_pkg::REG_POLL:  poll_r  <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      dgc_pkg::REG_MODES: cfg_prdata = {24'd0, modes_r};
      dgc_pkg::REG_ALOW:  cfg_prdata = {31'd0, alow_r};
      dgc_pkg::REG_DEB:   cfg_prdata = {16'd0, deb_r};
      dgc_pkg::REG_POLL:  cfg_prdata = {24'd0, poll_r};
      default:            cfg_prdata = '0;
    endcase
  end

  dgc_datapath u_dp (
    .clk, .rst_n, .in_item(in_ch.data), .cmd, .modes(modes_r), .alow(alow_r),
    .deb_ms(deb_r), .poll_ms(poll_r), .stat, .res(view)
  );

  dgc_ctrl u_ctrl (
    .clk, .rst_n, .in_ch, .out_ch, .stat, .view, .cmd
  );

  // one datapath step at a time; input taken only when idle; stall holds result
  a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.pulse_ch, cmd.poll_ch, cmd.init_ch, cmd.exec}))
    else $error("datapath got more than one step");
  a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> in_ch.ready) else $error("load without ready");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> out_ch.valid)
    else $error("result dropped under stall");
endmodule
`default_nettype wire

>>> sv/dgc_datapath.sv
`default_nettype none
module dgc_datapath (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire dgc_pkg::in_item_t  in_item,
  input  wire dgc_pkg::dp_cmd_t   cmd,
  input  wire logic [7:0]         modes,
  input  wire logic               alow,
  input  wire logic [15:0]        deb_ms,
  input  wire logic [7:0]         poll_ms,
  output dgc_pkg::dp_stat_t       stat,
  output dgc_pkg::out_item_t      res
);
  localparam int N = dgc_pkg::CHANNELS;
  localparam int CH_W_L = dgc_pkg::CH_W;

  logic [N-1:0]  en_r, act_r, hi_r, cand_r, pon_r, prest_r;
  logic [31:0]   csince_r [N];
  logic [23:0]   pleft_r [N];
  logic [31:0]   chg_r [N];
  logic [31:0]   now_r;
  logic [7:0]    phase_r;
  logic          poll_r;
  dgc_pkg::in_item_t item_r;

  logic [1:0]  mode;
  logic        is_out;
  logic [N-1:0] drive;
  logic [CH_W_L-1:0] ci;
  logic        cvalid;
  logic [23:0] pdec;
  logic        pin;
  logic [7:0]  iv, ph_inc;
  logic        deb_ok;

  // channel addressed by a command
  assign cvalid = (item_r.channel >= 3'd1) && (item_r.channel <= 3'(N));
  assign ci = cvalid ? CH_W_L'(item_r.channel - 3'd1) : '0;

  assign mode   = modes[2*cmd.idx +: 2];
  assign is_out = en_r[cmd.idx] && (mode == dgc_pkg::MODE_OUT);
  assign pdec   = pleft_r[cmd.idx] - 24'd1;
  assign pin    = item_r.pin_levels[cmd.idx];
  assign deb_ok = (now_r - csince_r[cmd.idx]) >= {16'd0, deb_ms};
  assign iv     = (poll_ms == 8'd0) ? 8'd1 : poll_ms;
  assign ph_inc = phase_r + 8'd1;

  always_comb begin
    for (int k = 0; k < N; k++)
      drive[k] = en_r[k] && (modes[2*k +: 2] == dgc_pkg::MODE_OUT) && hi_r[k];
  end

  // per-step status for the controller
  always_comb begin
    stat.item = item_r;
    stat.poll_now = poll_r;
    stat.init_stop = (mode == dgc_pkg::MODE_BAD);
    stat.sel_en = cvalid && en_r[ci];
    stat.sel_out = cvalid && en_r[ci] && (modes[2*ci +: 2] == dgc_pkg::MODE_OUT);
    stat.hit = 1'b0;
    if (cmd.pulse_ch)
      stat.hit = pon_r[cmd.idx] && (pdec == 24'd0) && is_out;
    else if (cmd.poll_ch)
      stat.hit = en_r[cmd.idx] && (mode == dgc_pkg::MODE_IN) &&
                 (pin == cand_r[cmd.idx]) && (pin != hi_r[cmd.idx]) && deb_ok;
  end

  // state updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r <= '0; act_r <= '0; hi_r <= '0; cand_r <= '0;
      pon_r <= '0; prest_r <= '0;
      for (int k = 0; k < N; k++) begin
        csince_r[k] <= '0; pleft_r[k] <= '0; chg_r[k] <= '0;
      end
      now_r <= '0; phase_r <= '0; poll_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        item_r <= in_item;
        if (in_item.command == dgc_pkg::CMD_TICK) begin
          now_r <= now_r + 32'd1;
          if (ph_inc >= iv) begin
            phase_r <= '0;
            poll_r <= 1'b1;
          end else begin
            phase_r <= ph_inc;
            poll_r <= 1'b0;
          end
        end
      end
      if (cmd.pulse_ch && pon_r[cmd.idx]) begin
        pleft_r[cmd.idx] <= pdec;
        if (pdec == 24'd0) begin
          pon_r[cmd.idx] <= 1'b0;
          if (is_out) begin
            act_r[cmd.idx] <= prest_r[cmd.idx];
            hi_r[cmd.idx]  <= prest_r[cmd.idx] ^ alow;
            chg_r[cmd.idx] <= now_r;
          end
        end
      end
      if (cmd.poll_ch && en_r[cmd.idx] && mode == dgc_pkg::MODE_IN) begin
        if (pin != cand_r[cmd.idx]) begin
          cand_r[cmd.idx]   <= pin;
          csince_r[cmd.idx] <= now_r;
        end else if (stat.hit) begin
          hi_r[cmd.idx]  <= pin;
          act_r[cmd.idx] <= pin ^ alow;
          chg_r[cmd.idx] <= now_r;
        end
      end
      if (cmd.init_ch) begin
        case (mode)
          dgc_pkg::MODE_OFF: begin
            en_r[cmd.idx] <= 1'b0; act_r[cmd.idx] <= 1'b0; hi_r[cmd.idx] <= 1'b0;
          end
          dgc_pkg::MODE_OUT: begin
            en_r[cmd.idx] <= 1'b1; act_r[cmd.idx] <= 1'b0; hi_r[cmd.idx] <= alow;
            chg_r[cmd.idx] <= now_r;
          end
          dgc_pkg::MODE_IN: begin
            en_r[cmd.idx] <= 1'b1; hi_r[cmd.idx] <= pin; act_r[cmd.idx] <= pin ^ alow;
            cand_r[cmd.idx] <= pin; csince_r[cmd.idx] <= now_r;
            chg_r[cmd.idx] <= now_r;
          end
          default: ;
        endcase
      end
      if (cmd.exec) begin
        case (dgc_pkg::cmd_t'(item_r.command))
          dgc_pkg::CMD_SAFE: begin
            for (int k = 0; k < N; k++)
              if (en_r[k] && modes[2*k +: 2] == dgc_pkg::MODE_OUT) begin
                pon_r[k] <= 1'b0; act_r[k] <= 1'b0; hi_r[k] <= alow;
                chg_r[k] <= now_r;
              end
          end
          dgc_pkg::CMD_SET, dgc_pkg::CMD_TOGGLE: begin
            if (cvalid) begin
              pon_r[ci] <= 1'b0;
              if (en_r[ci] && modes[2*ci +: 2] == dgc_pkg::MODE_OUT) begin
                act_r[ci] <= (item_r.command == dgc_pkg::CMD_SET) ?
                             item_r.value : !act_r[ci];
                hi_r[ci]  <= ((item_r.command == dgc_pkg::CMD_SET) ?
                             item_r.value : !act_r[ci]) ^ alow;
                chg_r[ci] <= now_r;
              end
            end
          end
          dgc_pkg::CMD_PULSE: begin
            if (cvalid && item_r.pulse_len != 24'd0 && en_r[ci] &&
                modes[2*ci +: 2] == dgc_pkg::MODE_OUT) begin
              prest_r[ci] <= act_r[ci];
              act_r[ci] <= item_r.value;
              hi_r[ci]  <= item_r.value ^ alow;
              chg_r[ci] <= now_r;
              pon_r[ci] <= 1'b1;
              pleft_r[ci] <= item_r.pulse_len;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // result view of a channel, taken from the current state
  logic [CH_W_L-1:0] vi;
  always_comb begin
    vi = (cmd.pulse_ch || cmd.poll_ch) ? cmd.idx : ci;
    res = '0;
    res.pin_drive = drive;
    res.chan_id = {1'b0, vi} + 3'd1;
    res.is_active = act_r[vi];
    res.pin_high = hi_r[vi];
    res.pulse_running = pon_r[vi];
    res.change_stamp = chg_r[vi];
    res.was_active = act_r[vi];
    // a hitting walk step reports the channel as it stands after this edge
    if (cmd.pulse_ch) begin
      res.is_active = prest_r[vi];
      res.pin_high = prest_r[vi] ^ alow;
      res.pulse_running = 1'b0;
      res.change_stamp = now_r;
      res.pin_drive[vi] = prest_r[vi] ^ alow;
    end else if (cmd.poll_ch) begin
      res.is_active = pin ^ alow;
      res.pin_high = pin;
      res.change_stamp = now_r;
    end
  end
endmodule
`default_nettype wire

>>> sv/dgc_ctrl.sv
`default_nettype none
module dgc_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  dgc_in_if.sink                  in_ch,
  dgc_out_if.source               out_ch,
  input  wire dgc_pkg::dp_stat_t  stat,
  input  wire dgc_pkg::out_item_t view,
  output dgc_pkg::dp_cmd_t        cmd
);
  localparam int W = dgc_pkg::CH_W;
  localparam int N = dgc_pkg::CHANNELS;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001, S_LOAD  = 7'b0000010, S_PULSE = 7'b0000100,
    S_POLL  = 7'b0001000, S_INIT  = 7'b0010000, S_EXEC  = 7'b0100000,
    S_FLUSH = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic [W-1:0] idx_r, idx_nxt;
  logic [1:0]   status_r, status_nxt;
  // one result in hand waiting to learn whether more follow
  logic         hold_r, hold_nxt;
  dgc_pkg::out_item_t held_r, held_nxt;
  logic         ov_r, ov_nxt;
  dgc_pkg::out_item_t od_r, od_nxt;
  logic         cvalid;
  logic [2:0]   cmdc;
  dgc_pkg::out_item_t reply;
  logic         last_idx;

  assign in_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = ov_r;
  assign out_ch.data = od_r;
  assign last_idx = (idx_r == W'(N - 1));
  assign cmdc = stat.item.command;
  assign cvalid = (stat.item.channel >= 3'd1) && (stat.item.channel <= 3'(N));

  // command reply built from channel view after execution
  always_comb begin
    reply = view;
    reply.kind = dgc_pkg::KIND_REPLY;
    reply.status = status_r;
    reply.was_active = 1'b0;
    reply.chan_id = stat.item.channel;
    reply.last = 1'b1;
    if (cmdc == dgc_pkg::CMD_INIT || cmdc == dgc_pkg::CMD_SAFE ||
        cmdc == dgc_pkg::CMD_BAD) begin
      reply.chan_id = 3'd0;
    end
    if (!cvalid || cmdc == dgc_pkg::CMD_INIT || cmdc == dgc_pkg::CMD_SAFE ||
        cmdc == dgc_pkg::CMD_BAD) begin
      reply.is_active = 1'b0; reply.pin_high = 1'b0;
      reply.pulse_running = 1'b0; reply.change_stamp = '0;
    end
  end

  always_comb begin
    cmd = '0;
    cmd.idx = idx_r;
    state_nxt = state_r;
    idx_nxt = idx_r;
    status_nxt = status_r;
    hold_nxt = hold_r;
    held_nxt = held_r;
    ov_nxt = ov_r;
    od_nxt = od_r;
    if (ov_r && out_ch.ready) ov_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          cmd.load = 1'b1;
          idx_nxt = '0;
          status_nxt = dgc_pkg::ST_OK;
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        case (dgc_pkg::cmd_t'(cmdc))
          dgc_pkg::CMD_TICK: state_nxt = S_PULSE;
          dgc_pkg::CMD_INIT: state_nxt = S_INIT;
          default: begin
            state_nxt = S_EXEC;
            case (dgc_pkg::cmd_t'(cmdc))
              dgc_pkg::CMD_SAFE: status_nxt = dgc_pkg::ST_OK;
              dgc_pkg::CMD_BAD: status_nxt = dgc_pkg::ST_ARG;
              dgc_pkg::CMD_GET:
                status_nxt = !cvalid ? dgc_pkg::ST_ARG :
                             (stat.sel_en ? dgc_pkg::ST_OK : dgc_pkg::ST_STATE);
              default: begin
                if (!cvalid || (cmdc == dgc_pkg::CMD_PULSE &&
                                stat.item.pulse_len == 24'd0))
                  status_nxt = dgc_pkg::ST_ARG;
                else if (!stat.sel_out)
                  status_nxt = dgc_pkg::ST_STATE;
              end
            endcase
          end
        endcase
      end
      S_PULSE, S_POLL: begin
        if (!hold_r || !ov_nxt) begin
          if (state_r == S_PULSE) cmd.pulse_ch = 1'b1;
          else cmd.poll_ch = 1'b1;
          if (stat.hit) begin
            if (hold_r) begin
              ov_nxt = 1'b1; od_nxt = held_r;
            end
            hold_nxt = 1'b1;
            held_nxt = view;
            held_nxt.kind = (state_r == S_PULSE) ? dgc_pkg::KIND_PULSE :
                            dgc_pkg::KIND_CHANGE;
            held_nxt.status = dgc_pkg::ST_OK;
            held_nxt.last = 1'b0;
            if (state_r == S_PULSE) held_nxt.was_active = 1'b0;
          end
          idx_nxt = idx_r + W'(1);
          if (last_idx) begin
            idx_nxt = '0;
            if (state_r == S_PULSE && stat.poll_now) state_nxt = S_POLL;
            else state_nxt = S_FLUSH;
          end
        end
      end
      S_INIT: begin
        cmd.init_ch = !stat.init_stop;
        idx_nxt = idx_r + W'(1);
        if (stat.init_stop) begin
          status_nxt = dgc_pkg::ST_ARG;
          state_nxt = S_EXEC;
        end else if (last_idx) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (!ov_nxt) begin
          cmd.exec = (cmdc != dgc_pkg::CMD_INIT) && (cmdc != dgc_pkg::CMD_GET);
          state_nxt = S_FLUSH;
          hold_nxt = 1'b1;
          held_nxt = reply;
        end
      end
      S_FLUSH: begin
        if (!ov_nxt) begin
          if (hold_r) begin
            // reply must see post-exec state
            if (cmdc != dgc_pkg::CMD_TICK) od_nxt = reply;
            else begin od_nxt = held_r; od_nxt.last = 1'b1; end
            ov_nxt = 1'b1;
          end
          hold_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; idx_r <= '0; status_r <= dgc_pkg::ST_OK;
      hold_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt; idx_r <= idx_nxt; status_r <= status_nxt;
      hold_r <= hold_nxt; ov_r <= ov_nxt;
    end
    held_r <= held_nxt;
    od_r <= od_nxt;
  end
endmodule
`default_nettype wire
